// ----- hdl/knnh_pkg.sv -----
// ----------------------------------------------------------------------------
// knnh_pkg
// Shared constants, types and helpers for the k-nearest-neighbor heap.
// ----------------------------------------------------------------------------
package knnh_pkg;

  // Heap capacity and coordinate precision
  localparam int unsigned MAX_NEIGHBORS = 32;
  localparam int unsigned COORD_BITS    = 20;

  // Fixed field widths
  localparam int unsigned FIELD_W    = 20;
  localparam int unsigned DIST_W     = 42;
  localparam int unsigned NCOUNT_W   = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 42;

  // Derived widths
  localparam int unsigned ABS_W  = COORD_BITS;
  localparam int unsigned PROD_W = 2 * ABS_W;
  localparam int unsigned IDX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_NEIGHBORS + 1);

  localparam logic [DIST_W-1:0] DIST_RESET = 42'd3298528591875;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST_SQ = 2'd3;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic [3*FIELD_W-1:0] coords;
    logic [DIST_W-1:0]    dist_sq;
  } heap_entry_t;

  localparam int unsigned ENTRY_W = $bits(heap_entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic  load_pt;
    logic  mul_en;
    axis_e mul_axis;
    logic  acc_load;
    logic  acc_add;
    logic  decide;
    logic  up_init;
    logic  dn_init;
    logic  wr_new;
    logic  cnt_inc;
    logic  move_up;
    logic  move_dn;
    logic  out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_range;
    logic full;
    logic pos_zero;
    logic up_stop;
    logic dn_leaf;
    logic dn_stop;
  } dp_status_t;

  // Sign-extend the low COORD_BITS bits of a coordinate field to the field width
  function automatic logic [FIELD_W-1:0] coord_field(input logic [FIELD_W-1:0] v);
    coord_field = FIELD_W'($signed(v[COORD_BITS-1:0]));
  endfunction

endpackage

// ----- hdl/knnh_ram.sv -----
// ----------------------------------------------------------------------------
// knnh_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module knnh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hdl/knnh_ctrl.sv -----
// ----------------------------------------------------------------------------
// knnh_ctrl
// Sequencer for distance accumulation, the accept decision and heap sifting.
// ----------------------------------------------------------------------------
module knnh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  knnh_pkg::dp_status_t  status_i,
  output knnh_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MX     = 4'd1;
  localparam logic [3:0] S_MY     = 4'd2;
  localparam logic [3:0] S_MZ     = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_UP_RD  = 4'd6;
  localparam logic [3:0] S_UP_CMP = 4'd7;
  localparam logic [3:0] S_DN_RD  = 4'd8;
  localparam logic [3:0] S_DN_CMP = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_axis = knnh_pkg::AXIS_X;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_pt = 1'b1;
          state_d       = S_MX;
        end
      end
      S_MX: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = knnh_pkg::AXIS_X;
        state_d        = S_MY;
      end
      S_MY: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = knnh_pkg::AXIS_Y;
        cmd_o.acc_load = 1'b1;
        state_d        = S_MZ;
      end
      S_MZ: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = knnh_pkg::AXIS_Z;
        cmd_o.acc_add  = 1'b1;
        state_d        = S_SUM;
      end
      S_SUM: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (!status_i.in_range) begin
          state_d = S_OUT;
        end else if (status_i.full) begin
          cmd_o.dn_init = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          cmd_o.up_init = 1'b1;
          state_d       = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (status_i.pos_zero) begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_OUT;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status_i.up_stop) begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd_o.move_up = 1'b1;
          state_d       = S_UP_RD;
        end
      end
      S_DN_RD: begin
        if (status_i.dn_leaf) begin
          cmd_o.wr_new = 1'b1;
          state_d      = S_OUT;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (status_i.dn_stop) begin
          cmd_o.wr_new = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.move_dn = 1'b1;
          state_d       = S_DN_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/knnh_dp.sv -----
// ----------------------------------------------------------------------------
// knnh_dp
// Datapath: configuration, distance unit, heap memory and result registers.
// ----------------------------------------------------------------------------
module knnh_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [knnh_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [knnh_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 restart_i,
  input  logic [knnh_pkg::FIELD_W-1:0]         pt_x_i,
  input  logic [knnh_pkg::FIELD_W-1:0]         pt_y_i,
  input  logic [knnh_pkg::FIELD_W-1:0]         pt_z_i,
  input  knnh_pkg::ctrl_cmd_t                  cmd_i,
  output knnh_pkg::dp_status_t                 status_o,
  output logic                                 accepted_o,
  output logic [knnh_pkg::NCOUNT_W-1:0]        neighbor_count_o,
  output logic [knnh_pkg::DIST_W-1:0]          radius_sq_o
);

  localparam int unsigned CB = knnh_pkg::COORD_BITS;
  localparam int unsigned IW = knnh_pkg::IDX_W;

  // Absolute difference of two coordinates, both sign-extended from CB bits
  function automatic logic [knnh_pkg::ABS_W-1:0] abs_diff(
    input logic [knnh_pkg::FIELD_W-1:0] p,
    input logic [CB-1:0]                q
  );
    logic signed [CB:0] d;
    logic signed [CB:0] a;
    d = $signed({p[CB-1], p[CB-1:0]}) - $signed({q[CB-1], q});
    a = d[CB] ? -d : d;
    abs_diff = a[knnh_pkg::ABS_W-1:0];
  endfunction

  // Configuration registers
  logic [CB-1:0]               qx_q, qy_q, qz_q;
  logic [knnh_pkg::DIST_W-1:0] max_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q       <= '0;
      qy_q       <= '0;
      qz_q       <= '0;
      max_dist_q <= knnh_pkg::DIST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        knnh_pkg::REG_QUERY_X:     qx_q       <= cfg_data_i[CB-1:0];
        knnh_pkg::REG_QUERY_Y:     qy_q       <= cfg_data_i[CB-1:0];
        knnh_pkg::REG_QUERY_Z:     qz_q       <= cfg_data_i[CB-1:0];
        knnh_pkg::REG_MAX_DIST_SQ: max_dist_q <= cfg_data_i[knnh_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Point capture and distance accumulation
  logic [3*knnh_pkg::FIELD_W-1:0] coords_q;
  logic [knnh_pkg::ABS_W-1:0]     ax_q, ay_q, az_q;
  logic [knnh_pkg::ABS_W-1:0]     mul_op;
  logic [knnh_pkg::PROD_W-1:0]    prod_q;
  logic [knnh_pkg::DIST_W-1:0]    acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      coords_q <= {knnh_pkg::coord_field(pt_z_i), knnh_pkg::coord_field(pt_y_i),
                   knnh_pkg::coord_field(pt_x_i)};
      ax_q     <= abs_diff(pt_x_i, qx_q);
      ay_q     <= abs_diff(pt_y_i, qy_q);
      az_q     <= abs_diff(pt_z_i, qz_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_op * mul_op;
    end
    if (cmd_i.acc_load) begin
      acc_q <= knnh_pkg::DIST_W'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + knnh_pkg::DIST_W'(prod_q);
    end
  end

  always_comb begin
    case (cmd_i.mul_axis)
      knnh_pkg::AXIS_X: mul_op = ax_q;
      knnh_pkg::AXIS_Y: mul_op = ay_q;
      knnh_pkg::AXIS_Z: mul_op = az_q;
      default:          mul_op = ax_q;
    endcase
  end

  // Heap walk
  logic [knnh_pkg::CNT_W-1:0]  count_q;
  logic [IW-1:0]               pos_q;
  logic                        dn_q;
  logic [IW-1:0]               parent;
  logic [IW+1:0]               c1_w, c2_w;
  logic                        c2_ok;
  knnh_pkg::heap_entry_t       rd_a, rd_b, best_entry, wr_entry;
  logic                        a_gt, b_best;
  logic [IW-1:0]               best_idx;
  logic                        mem_we;
  logic [IW-1:0]               raddr_a;

  assign parent = IW'((pos_q - 1'b1) >> 1);
  assign c1_w   = {1'b0, pos_q, 1'b1};
  assign c2_w   = c1_w + 1'b1;
  assign c2_ok  = (c2_w < (IW + 2)'(knnh_pkg::MAX_NEIGHBORS));
  assign raddr_a = dn_q ? c1_w[IW-1:0] : parent;

  assign a_gt       = (rd_a.dist_sq > acc_q);
  assign b_best     = c2_ok && (rd_b.dist_sq > (a_gt ? rd_a.dist_sq : acc_q));
  assign best_entry = b_best ? rd_b : rd_a;
  assign best_idx   = b_best ? c2_w[IW-1:0] : c1_w[IW-1:0];

  assign mem_we = cmd_i.wr_new | cmd_i.move_up | cmd_i.move_dn;

  always_comb begin
    if (cmd_i.wr_new) begin
      wr_entry.coords  = coords_q;
      wr_entry.dist_sq = acc_q;
    end else if (cmd_i.move_up) begin
      wr_entry = rd_a;
    end else begin
      wr_entry = best_entry;
    end
  end

  knnh_ram #(
    .WIDTH (knnh_pkg::ENTRY_W),
    .DEPTH (knnh_pkg::MAX_NEIGHBORS)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (pos_q),
    .wdata_i   (wr_entry),
    .raddr_a_i (raddr_a),
    .raddr_b_i (c2_w[IW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.up_init) begin
      pos_q <= IW'(count_q);
      dn_q  <= 1'b0;
    end else if (cmd_i.dn_init) begin
      pos_q <= '0;
      dn_q  <= 1'b1;
    end else if (cmd_i.move_up) begin
      pos_q <= parent;
    end else if (cmd_i.move_dn) begin
      pos_q <= best_idx;
    end
  end

  // Shadow of the root distance, kept current on every write to the root slot
  logic [knnh_pkg::DIST_W-1:0] root_q;

  always_ff @(posedge clk_i) begin
    if (mem_we && (pos_q == '0)) begin
      root_q <= wr_entry.dist_sq;
    end
  end

  // Collection state and results
  logic [knnh_pkg::DIST_W-1:0] radius_q, radius_d;
  logic                        rad_upd_q;
  logic                        acc_flag_q;
  logic                        out_acc_q;
  logic [knnh_pkg::NCOUNT_W-1:0] out_cnt_q;
  logic [knnh_pkg::DIST_W-1:0] out_radius_q;

  assign radius_d = rad_upd_q ? root_q : radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      radius_q   <= knnh_pkg::DIST_RESET;
      rad_upd_q  <= 1'b0;
      acc_flag_q <= 1'b0;
    end else begin
      if (cmd_i.load_pt) begin
        rad_upd_q  <= 1'b0;
        acc_flag_q <= 1'b0;
        if (restart_i) begin
          count_q  <= '0;
          radius_q <= max_dist_q;
        end
      end
      if (cmd_i.decide) begin
        acc_flag_q <= status_o.in_range;
      end
      if (cmd_i.wr_new) begin
        // A sift-down always moves the root; a sift-up moves it once the heap fills
        rad_upd_q <= !cmd_i.cnt_inc ||
                     (count_q == knnh_pkg::CNT_W'(knnh_pkg::MAX_NEIGHBORS - 1));
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        radius_q <= radius_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_acc_q    <= acc_flag_q;
      out_cnt_q    <= knnh_pkg::NCOUNT_W'(count_q);
      out_radius_q <= radius_d;
    end
  end

  assign status_o.in_range = (acc_q < radius_q);
  assign status_o.full     = (count_q == knnh_pkg::CNT_W'(knnh_pkg::MAX_NEIGHBORS));
  assign status_o.pos_zero = (pos_q == '0);
  assign status_o.up_stop  = (rd_a.dist_sq >= acc_q);
  assign status_o.dn_leaf  = (c1_w >= (IW + 2)'(knnh_pkg::MAX_NEIGHBORS));
  assign status_o.dn_stop  = !a_gt && !b_best;

  assign accepted_o       = out_acc_q;
  assign neighbor_count_o = out_cnt_q;
  assign radius_sq_o      = out_radius_q;

endmodule

// ----- hdl/k_nearest_neighbor_heap.sv -----
// ----------------------------------------------------------------------------
// k_nearest_neighbor_heap
// Keeps the nearest points to a query point in a bounded max-heap ordered by
// squared distance, and reports one result transaction for every point
// transaction: whether the point was taken, how many neighbors are held, and
// the current squared search radius. A point is taken only when its squared
// distance is strictly below the radius; while the heap has room it is sifted
// up, and once the heap is full it replaces the root, is sifted down, and the
// radius drops to the new root distance. Setting restart on a point empties
// the collection and reloads the radius from max_dist_sq before that point is
// handled. One point is in flight at a time: a rejected point goes through
// capture, the three squares, the final add, the decision and the result
// register. A sift-up reads and compares at each level climbed, and ends at
// the root or when a parent at an equal or larger distance stops it; a
// sift-down reads and compares at each level descended, and ends at a leaf
// or when neither child is larger. With a heap of 32 entries a sift climbs at
// most 5 levels and descends at most 5, and a result may also wait for an
// earlier result to drain downstream. The sequence is set by the single shared
// squarer (three axes in turn plus a final add) and by the heap memory, whose
// read data is registered and is fetched at each level of the sift. The next
// point is taken while the previous result still waits downstream.
// Configuration writes are accepted in every cycle and belong between points.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_heap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [knnh_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [knnh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // point transactions
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             restart_i,
  input  logic [knnh_pkg::FIELD_W-1:0]     pt_x_i,
  input  logic [knnh_pkg::FIELD_W-1:0]     pt_y_i,
  input  logic [knnh_pkg::FIELD_W-1:0]     pt_z_i,
  // result transactions
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             accepted_o,
  output logic [knnh_pkg::NCOUNT_W-1:0]    neighbor_count_o,
  output logic [knnh_pkg::DIST_W-1:0]      radius_sq_o
);

  knnh_pkg::ctrl_cmd_t  cmd;
  knnh_pkg::dp_status_t status;

  // Registers are always writable; software keeps writes between points
  assign cfg_ready_o = 1'b1;

  // Sequence each point: capture, square and sum, decide, sift, report
  knnh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the query, the heap memory and the result registers
  knnh_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .restart_i        (restart_i),
    .pt_x_i           (pt_x_i),
    .pt_y_i           (pt_y_i),
    .pt_z_i           (pt_z_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .accepted_o       (accepted_o),
    .neighbor_count_o (neighbor_count_o),
    .radius_sq_o      (radius_sq_o)
  );

endmodule

// ----- hdl/knnh_checker.sv -----
// ----------------------------------------------------------------------------
// knnh_checker
// Port-level checks for the k-nearest-neighbor heap, bound to the top level.
// ----------------------------------------------------------------------------
module knnh_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [knnh_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [knnh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             restart_i,
  input logic [knnh_pkg::FIELD_W-1:0]     pt_x_i,
  input logic [knnh_pkg::FIELD_W-1:0]     pt_y_i,
  input logic [knnh_pkg::FIELD_W-1:0]     pt_z_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             accepted_o,
  input logic [knnh_pkg::NCOUNT_W-1:0]    neighbor_count_o,
  input logic [knnh_pkg::DIST_W-1:0]      radius_sq_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o) &&
      $stable(neighbor_count_o) && $stable(radius_sq_o))
    else $error("result changed while stalled");

  // One point at a time: a taken point closes the input until it is done
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second point taken while one is in flight");

  // A taken point leaves at least one neighbor in the heap
  a_accept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> neighbor_count_o != '0)
    else $error("accepted point with empty heap");

  // The heap never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> neighbor_count_o <= knnh_pkg::NCOUNT_W'(knnh_pkg::MAX_NEIGHBORS))
    else $error("neighbor count beyond capacity");

endmodule

bind k_nearest_neighbor_heap knnh_checker u_knnh_checker (.*);

// ----- sim/tb_k_nearest_neighbor_heap.sv -----
// ----------------------------------------------------------------------------
// tb_k_nearest_neighbor_heap
// Self-checking bench for the k-nearest-neighbor heap. A queue of pending
// point, register-write and drain actions feeds a falling-edge driver; a
// rising-edge monitor runs a local heap predictor on every accepted point
// transaction and compares each result transaction, field by field, with the
// oldest prediction. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_k_nearest_neighbor_heap;
  timeunit 1ns;
  timeprecision 1ps;

  import knnh_pkg::*;

  // Idle cycles without any transaction before the run is declared hung. The
  // limit leaves a wide margin over the slowest item plus the longest sender
  // gap and the longest receiver stall.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned POINT_ITEMS = 600;

  localparam logic [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [DIST_W-1:0]  RADIUS_ALL_ONES = '1;

  typedef enum logic [1:0] {
    ACT_POINT,
    ACT_CONFIG,
    ACT_DRAIN
  } stim_kind_e;

  // How a random point is placed relative to the query point
  typedef enum logic [1:0] {
    PT_NEAR,
    PT_ANY,
    PT_EDGE,
    PT_SAME
  } pt_style_e;

  typedef struct {
    stim_kind_e            kind;
    logic                  restart;
    logic [FIELD_W-1:0]    x;
    logic [FIELD_W-1:0]    y;
    logic [FIELD_W-1:0]    z;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } stim_t;

  typedef struct packed {
    logic                accepted;
    logic [NCOUNT_W-1:0] count;
    logic [DIST_W-1:0]   radius;
  } nn_result_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  restart = 1'b0;
  logic [FIELD_W-1:0]    pt_x = '0;
  logic [FIELD_W-1:0]    pt_y = '0;
  logic [FIELD_W-1:0]    pt_z = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  accepted;
  logic [NCOUNT_W-1:0]   neighbor_count;
  logic [DIST_W-1:0]     radius_sq;

  k_nearest_neighbor_heap i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .restart_i        (restart),
    .pt_x_i           (pt_x),
    .pt_y_i           (pt_y),
    .pt_z_i           (pt_z),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .accepted_o       (accepted),
    .neighbor_count_o (neighbor_count),
    .radius_sq_o      (radius_sq)
  );

  // 20 ns period
  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  stim_t       pending [$];     // actions not yet handed to the DUT
  nn_result_t  results_due [$]; // predicted results, oldest first
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned pts_queued = 0;
  logic        in_fire_q = 1'b0;
  logic        cfg_fire_q = 1'b0;

  // Sender and receiver pacing
  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;
  int unsigned sink_hold = 0;
  bit          sink_burst = 1'b0;

  // Predictor copy of the registers and the heap
  longint              qry_x, qry_y, qry_z;
  logic [DIST_W-1:0]   radius_init;
  logic [3*FIELD_W-1:0] nb_coords [MAX_NEIGHBORS];
  logic [DIST_W-1:0]   nb_dist [MAX_NEIGHBORS];
  int unsigned         nb_count;
  logic [DIST_W-1:0]   nb_radius;

  // Query point as the stimulus builder last wrote it, used to aim points
  logic [FIELD_W-1:0]  aim_q [3];

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_coord(input logic [FIELD_W-1:0] q,
                                                    input pt_style_e style);
    logic [31:0] r;
    r = $urandom();
    case (style)
      // small offsets around the query give many equal distances
      PT_NEAR: pick_coord = q + FIELD_W'($urandom_range(0, 120)) - FIELD_W'(60);
      PT_ANY:  pick_coord = r[FIELD_W-1:0];
      PT_EDGE: begin
        case (r[1:0])
          2'd0:    pick_coord = COORD_MIN;
          2'd1:    pick_coord = COORD_MAX;
          2'd2:    pick_coord = '0;
          default: pick_coord = '1;
        endcase
      end
      default: pick_coord = q;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: offer one point to the local heap and return the result
  // --------------------------------------------------------------------------
  task automatic offer_point(input logic rs, input logic [FIELD_W-1:0] x, y, z,
                             output nn_result_t res);
    longint               px, py, pz, dx, dy, dz;
    logic [63:0]          sum;
    logic [DIST_W-1:0]    d, bval;
    logic [3*FIELD_W-1:0] packed_pt;
    int unsigned          pos, parent, best, c;
    bit                   stop;
    // sign-extend from the coordinate precision
    px = $signed(x[COORD_BITS-1:0]);
    py = $signed(y[COORD_BITS-1:0]);
    pz = $signed(z[COORD_BITS-1:0]);
    packed_pt = {pz[FIELD_W-1:0], py[FIELD_W-1:0], px[FIELD_W-1:0]};
    if (rs) begin
      nb_count = 0;
      nb_radius = radius_init;
    end
    dx = px - qry_x;
    dy = py - qry_y;
    dz = pz - qry_z;
    sum = dx * dx + dy * dy + dz * dz;
    d = sum[DIST_W-1:0];
    res.accepted = 1'b0;
    // a point exactly at the radius stays out
    if (d < nb_radius) begin
      res.accepted = 1'b1;
      if (nb_count < MAX_NEIGHBORS) begin
        // climb while the parent is strictly nearer; an equal parent stops it
        pos = nb_count;
        stop = 1'b0;
        while (pos > 0 && !stop) begin
          parent = (pos - 1) >> 1;
          if (nb_dist[parent] >= d) begin
            stop = 1'b1;
          end else begin
            nb_coords[pos] = nb_coords[parent];
            nb_dist[pos] = nb_dist[parent];
            pos = parent;
          end
        end
        nb_coords[pos] = packed_pt;
        nb_dist[pos] = d;
        nb_count++;
        if (nb_count == MAX_NEIGHBORS) nb_radius = nb_dist[0];
      end else begin
        // replace the root and sink; the left child wins a tie
        pos = 0;
        stop = 1'b0;
        while (!stop) begin
          best = pos;
          bval = d;
          c = 2 * pos + 1;
          if (c < MAX_NEIGHBORS && nb_dist[c] > bval) begin
            best = c;
            bval = nb_dist[c];
          end
          c++;
          if (c < MAX_NEIGHBORS && nb_dist[c] > bval) begin
            best = c;
            bval = nb_dist[c];
          end
          if (best == pos) begin
            stop = 1'b1;
          end else begin
            nb_coords[pos] = nb_coords[best];
            nb_dist[pos] = nb_dist[best];
            pos = best;
          end
        end
        nb_coords[pos] = packed_pt;
        nb_dist[pos] = d;
        nb_radius = nb_dist[0];
      end
    end
    res.count = nb_count[NCOUNT_W-1:0];
    res.radius = nb_radius;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic add_point(input logic rs, input logic [FIELD_W-1:0] x, y, z);
    stim_t s;
    s = '{kind: ACT_POINT, restart: rs, x: x, y: y, z: z, idx: '0, data: '0};
    pending.push_back(s);
    pts_queued++;
  endtask

  task automatic add_config(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    stim_t s;
    s = '{kind: ACT_CONFIG, restart: 1'b0, x: '0, y: '0, z: '0, idx: idx, data: data};
    pending.push_back(s);
    // keep the aim point in step with the query registers
    case (idx)
      REG_QUERY_X: aim_q[0] = data[FIELD_W-1:0];
      REG_QUERY_Y: aim_q[1] = data[FIELD_W-1:0];
      REG_QUERY_Z: aim_q[2] = data[FIELD_W-1:0];
      default: ;
    endcase
  endtask

  // Hold the sender until every predicted result has come back
  task automatic add_drain();
    stim_t s;
    s = '{kind: ACT_DRAIN, restart: 1'b0, x: '0, y: '0, z: '0, idx: '0, data: '0};
    pending.push_back(s);
  endtask

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge, one transaction at a time.
  // Register writes and drains wait for an empty prediction queue, which
  // means no point is inside the block.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : point_driver
    stim_t head;
    logic  nxt_in;
    logic  nxt_cfg;
    nxt_in = in_valid;
    nxt_cfg = cfg_valid;
    // drop valid once the transaction went through at the last rising edge
    if (in_fire_q) nxt_in = 1'b0;
    if (cfg_fire_q) nxt_cfg = 1'b0;
    if (rst_n && !nxt_in && !nxt_cfg) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
      end else if (pending.size() > 0) begin
        head = pending[0];
        case (head.kind)
          ACT_POINT: begin
            void'(pending.pop_front());
            restart <= head.restart;
            pt_x <= head.x;
            pt_y <= head.y;
            pt_z <= head.z;
            nxt_in = 1'b1;
            // switch now and then between paced and back-to-back traffic
            if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
            send_gap = (send_burst || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
          end
          ACT_CONFIG: begin
            if (results_due.size() == 0) begin
              void'(pending.pop_front());
              cfg_index <= head.idx;
              cfg_data <= head.data;
              nxt_cfg = 1'b1;
            end
          end
          default: begin
            if (results_due.size() == 0) void'(pending.pop_front());
          end
        endcase
      end
    end
    in_valid <= nxt_in;
    cfg_valid <= nxt_cfg;
  end

  // Receiver: random stalls on the result channel, with burst stretches
  always @(negedge clk) begin : result_sink
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
      if (!sink_burst && $urandom_range(0, 2) == 0) sink_hold = pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample handshakes on the rising edge, predict, compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    nn_result_t exp_res;
    nn_result_t new_res;
    if (!rst_n) begin
      qry_x = 0;
      qry_y = 0;
      qry_z = 0;
      radius_init = DIST_RESET;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        nb_coords[i] = '0;
        nb_dist[i] = '0;
      end
      nb_count = 0;
      nb_radius = DIST_RESET;
      in_fire_q <= 1'b0;
      cfg_fire_q <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUERY_X:     qry_x = $signed(cfg_data[COORD_BITS-1:0]);
          REG_QUERY_Y:     qry_y = $signed(cfg_data[COORD_BITS-1:0]);
          REG_QUERY_Z:     qry_z = $signed(cfg_data[COORD_BITS-1:0]);
          REG_MAX_DIST_SQ: radius_init = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      // match the result first so a new prediction never pairs with it
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result transaction with no point outstanding");
          errors++;
        end else begin
          exp_res = results_due.pop_front();
          if (accepted !== exp_res.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_res.accepted, accepted);
            errors++;
          end
          if (neighbor_count !== exp_res.count) begin
            $error("neighbor_count: expected %0d, got %0d", exp_res.count,
                   neighbor_count);
            errors++;
          end
          if (radius_sq !== exp_res.radius) begin
            $error("radius_sq: expected %0d, got %0d", exp_res.radius, radius_sq);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        offer_point(restart, pt_x, pt_y, pt_z, new_res);
        results_due.push_back(new_res);
      end
      in_fire_q <= in_valid && in_ready;
      cfg_fire_q <= cfg_valid && cfg_ready;
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Hang detector
  initial begin : watchdog
    @(posedge rst_n);
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0]          r;
    logic [63:0]          w;
    logic [FIELD_W-1:0]   qc;
    logic [DIST_W-1:0]    rad;
    pt_style_e            style;
    int unsigned          seq_len;
    int unsigned          seq_no;
    aim_q[0] = '0;
    aim_q[1] = '0;
    aim_q[2] = '0;

    // --- directed: reset query at the origin, radius at its reset value
    add_point(1'b1, '0, '0, '0);
    add_point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
    add_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
    add_point(1'b0, COORD_MAX, COORD_MIN, '0);
    // equal distances in the heap
    add_point(1'b0, '0, '0, '0);
    add_point(1'b0, '0, '0, '0);

    // query in the far corner: the opposite corner lands exactly on the radius
    add_drain();
    add_config(REG_QUERY_X, CFG_DATA_W'(COORD_MAX));
    add_config(REG_QUERY_Y, CFG_DATA_W'(COORD_MAX));
    add_config(REG_QUERY_Z, CFG_DATA_W'(COORD_MAX));
    add_point(1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
    add_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
    add_point(1'b0, COORD_MIN, COORD_MAX, COORD_MAX);

    // zero radius rejects everything, even the query point itself
    add_config(REG_QUERY_X, CFG_DATA_W'(COORD_MIN));
    add_config(REG_QUERY_Y, CFG_DATA_W'(COORD_MIN));
    add_config(REG_QUERY_Z, CFG_DATA_W'(COORD_MIN));
    add_config(REG_MAX_DIST_SQ, '0);
    add_point(1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
    add_point(1'b0, COORD_MAX, '0, COORD_MIN);

    // all-ones radius
    add_config(REG_QUERY_X, '0);
    add_config(REG_QUERY_Y, '0);
    add_config(REG_QUERY_Z, '0);
    add_config(REG_MAX_DIST_SQ, CFG_DATA_W'(RADIUS_ALL_ONES));
    add_point(1'b1, FIELD_W'(1), FIELD_W'(1), FIELD_W'(1));
    add_point(1'b0, '1, '1, '1);

    // tiny radius: distance 2 passes, distance 3 sits on the edge
    add_config(REG_MAX_DIST_SQ, CFG_DATA_W'(3));
    add_point(1'b1, FIELD_W'(1), FIELD_W'(1), '0);
    add_point(1'b0, FIELD_W'(1), FIELD_W'(1), FIELD_W'(1));
    add_point(1'b0, '0, '0, FIELD_W'(1));
    add_point(1'b0, '1, '0, '0);

    // --- random: restart-led sequences, long enough to fill and churn the heap
    seq_no = 0;
    while (pts_queued < POINT_ITEMS) begin
      if (seq_no == 0 || $urandom_range(0, 2) == 0) begin
        for (int ax = 0; ax < 3; ax++) begin
          r = $urandom();
          qc = ($urandom_range(0, 5) == 0) ? pick_coord('0, PT_EDGE) : r[FIELD_W-1:0];
          // upper data bits are don't-care for a coordinate; fill them anyway
          w = {$urandom(), $urandom()};
          add_config(ax == 0 ? REG_QUERY_X : (ax == 1 ? REG_QUERY_Y : REG_QUERY_Z),
                     {w[CFG_DATA_W-FIELD_W-1:0], qc});
        end
        r = $urandom_range(0, 99);
        w = {$urandom(), $urandom()};
        if (r < 25)      rad = DIST_RESET;
        else if (r < 35) rad = RADIUS_ALL_ONES;
        else if (r < 40) rad = '0;
        else if (r < 70) rad = DIST_W'($urandom_range(0, 20000));
        else             rad = w[DIST_W-1:0];
        add_config(REG_MAX_DIST_SQ, CFG_DATA_W'(rad));
      end else if ($urandom_range(0, 3) == 0) begin
        add_drain();
      end
      seq_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                            : $urandom_range(33, 70);
      for (int k = 0; k < seq_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 50)      style = PT_NEAR;
        else if (r < 85) style = PT_ANY;
        else if (r < 95) style = PT_EDGE;
        else             style = PT_SAME;
        if (k > 0 && $urandom_range(0, 59) == 0) add_drain();
        // the first point restarts; a stray restart now and then breaks a run
        add_point(k == 0 || $urandom_range(0, 39) == 0,
                  pick_coord(aim_q[0], style), pick_coord(aim_q[1], style),
                  pick_coord(aim_q[2], style));
      end
      seq_no++;
    end

    // release reset on a falling edge; drivers see it from the next one
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for the stimulus and every result, then let late outputs show up
    @(negedge clk);
    while (pending.size() != 0 || in_valid || cfg_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (results_due.size() != 0) begin
      $error("%0d predicted results never arrived", results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
